FILE: rtl/fbic_pkg.sv
package fbic_pkg;

  // Default table depth and the address space that a freed block must fit in.
  localparam int MAX_BLOCKS_DEF = 64;
  localparam int ADDR_BITS      = 32;

  // Fixed field widths of the request and result ports.
  localparam int START_W  = 32;
  localparam int SIZE_W   = 32;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;

  // The shared adder works on 34 bits: three 32-bit sizes never carry past bit 33.
  localparam int ALU_W = 34;

  // One past the last legal address. At 33 bits and above no block can pass it.
  localparam logic [ALU_W-1:0] SPACE_LIMIT = (ADDR_BITS >= ALU_W - 1) ?
                                             (ALU_W'(1) << (ALU_W - 1)) :
                                             (ALU_W'(1) << ADDR_BITS);

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_NEW     = 3'd0,
    ST_NEXT    = 3'd1,
    ST_PREV    = 3'd2,
    ST_BOTH    = 3'd3,
    ST_REFUSED = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LIM,
    S_NXT,
    S_PRV,
    S_DEC,
    S_SUM1,
    S_SUM2,
    S_WR,
    S_UP,
    S_DN,
    S_DONE
  } state_e;

  // One free table entry as stored in the table RAM.
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
  } entry_t;

  // Result of the shared add and compare unit.
  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             lt;
    logic             eq;
  } alu_res_t;

endpackage

FILE: rtl/fbic_ram.sv
module fbic_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fbic_alu.sv
module fbic_alu (
  input  logic [fbic_pkg::ALU_W-1:0] a_i,
  input  logic [fbic_pkg::ALU_W-1:0] b_i,
  input  logic [fbic_pkg::ALU_W-1:0] c_i,
  output fbic_pkg::alu_res_t         res_o
);

  logic [fbic_pkg::ALU_W-1:0] sum;

  // Shared unit: one add, then the sum is compared against a third operand.
  always_comb begin
    sum       = a_i + b_i;
    res_o.sum = sum;
    res_o.lt  = (sum < c_i);
    res_o.eq  = (sum == c_i);
  end

endmodule

FILE: rtl/free_block_insert_coalesce_core.sv
// Free-block table with coalescing. Each request frees one block (start, size) into a
// table of up to MAX_BLOCKS free entries kept sorted by start address; the block merges
// with the following entry when it ends where that entry starts and with the preceding
// entry when that one ends where it starts, and it is refused when its size is zero,
// when it ends past the address space, or when the table is full and nothing merges.
// One request is worked on at a time. The scan and the slot move walk the table one
// entry per cycle through the single-read-port table RAM; three checks and up to two
// size sums go through the one shared 34-bit adder. The table starts empty after reset
// and needs no clearing pass. A finished result waits in an output register, so the
// next request is taken while it is still pending.
module free_block_insert_coalesce_core #(
  parameter int MAX_BLOCKS = fbic_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fbic_pkg::START_W-1:0]   block_start_i,
  input  logic [fbic_pkg::SIZE_W-1:0]    block_size_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fbic_pkg::STATUS_W-1:0]  status_o,
  output logic [fbic_pkg::INDEX_W-1:0]   entry_index_o,
  output logic [fbic_pkg::START_W-1:0]   merged_start_o,
  output logic [fbic_pkg::SIZE_W-1:0]    merged_size_o,
  output logic [fbic_pkg::COUNT_W-1:0]   entry_count_o
);

  localparam int IW    = $clog2(MAX_BLOCKS);
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int ALU_W = fbic_pkg::ALU_W;

  // Control registers.
  fbic_pkg::state_e state_q, state_d;
  logic [CW-1:0]    n_q, n_d;
  logic             out_valid_q, out_valid_d;

  // Working registers of the current request.
  logic [fbic_pkg::START_W-1:0] bstart_q, bstart_d;
  logic [fbic_pkg::SIZE_W-1:0]  bsize_q, bsize_d;
  logic [CW-1:0]                pos_q, pos_d;
  logic [IW-1:0]                sh_q, sh_d;
  fbic_pkg::entry_t             prev_q, prev_d;
  fbic_pkg::entry_t             next_q, next_d;
  logic                         range_bad_q, range_bad_d;
  logic                         mnext_q, mnext_d;
  logic                         mprev_q, mprev_d;
  logic [ALU_W-1:0]             acc_q, acc_d;
  logic [fbic_pkg::START_W-1:0] res_start_q, res_start_d;
  logic [IW-1:0]                idx_q, idx_d;
  fbic_pkg::status_e            status_q, status_d;

  // Result register.
  fbic_pkg::status_e            out_status_q, out_status_d;
  logic [fbic_pkg::INDEX_W-1:0] out_index_q, out_index_d;
  logic [fbic_pkg::START_W-1:0] out_start_q, out_start_d;
  logic [fbic_pkg::SIZE_W-1:0]  out_size_q, out_size_d;
  logic [fbic_pkg::COUNT_W-1:0] out_count_q, out_count_d;

  // Table RAM and shared unit connections.
  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  fbic_pkg::entry_t           ram_wdata;
  logic [IW-1:0]              ram_raddr;
  logic [$bits(fbic_pkg::entry_t)-1:0] ram_rdata_raw;
  fbic_pkg::entry_t           ram_rdata;
  logic [ALU_W-1:0]           alu_a, alu_b, alu_c;
  fbic_pkg::alu_res_t         alu_res;

  // Helper values.
  logic [CW-1:0]              pos_m1, n_m1, pos_p1, n_next;
  logic [fbic_pkg::SIZE_W-1:0] sat_size;
  logic                       refuse;

  fbic_ram #(
    .WIDTH ($bits(fbic_pkg::entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = fbic_pkg::entry_t'(ram_rdata_raw);

  fbic_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .res_o (alu_res)
  );

  assign pos_m1   = pos_q - CW'(1);
  assign pos_p1   = pos_q + CW'(1);
  assign n_m1     = n_q - CW'(1);
  assign sat_size = (acc_q[ALU_W-1:fbic_pkg::SIZE_W] != '0) ? '1 : acc_q[fbic_pkg::SIZE_W-1:0];
  assign refuse   = (bsize_q == '0) || range_bad_q ||
                    (!mnext_q && !mprev_q && (n_q >= CW'(MAX_BLOCKS)));

  // Count after the current request completes.
  always_comb begin
    case (status_q)
      fbic_pkg::ST_NEW:  n_next = n_q + CW'(1);
      fbic_pkg::ST_BOTH: n_next = n_q - CW'(1);
      default:           n_next = n_q;
    endcase
  end

  // Sequencer: next state, shared unit operands, table accesses.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    out_valid_d = out_valid_q;
    bstart_d    = bstart_q;
    bsize_d     = bsize_q;
    pos_d       = pos_q;
    sh_d        = sh_q;
    prev_d      = prev_q;
    next_d      = next_q;
    range_bad_d = range_bad_q;
    mnext_d     = mnext_q;
    mprev_d     = mprev_q;
    acc_d       = acc_q;
    res_start_d = res_start_q;
    idx_d       = idx_q;
    status_d    = status_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_start_d  = out_start_q;
    out_size_d   = out_size_q;
    out_count_d  = out_count_q;

    alu_a     = '0;
    alu_b     = '0;
    alu_c     = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    in_ready_o = 1'b0;

    // The result register empties when the consumer takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      fbic_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        ram_raddr  = '0;
        if (in_valid_i) begin
          bstart_d = block_start_i;
          bsize_d  = block_size_i;
          pos_d    = '0;
          state_d  = (n_q == '0) ? fbic_pkg::S_LIM : fbic_pkg::S_SCAN;
        end
      end

      // Walk the table until an entry does not start below the block.
      fbic_pkg::S_SCAN: begin
        alu_a     = ALU_W'(ram_rdata.start);
        alu_c     = ALU_W'(bstart_q);
        ram_raddr = pos_q[IW-1:0] + IW'(1);
        if (alu_res.lt) begin
          prev_d = ram_rdata;
          pos_d  = pos_p1;
          if (pos_p1 == n_q) begin
            state_d = fbic_pkg::S_LIM;
          end
        end else begin
          next_d  = ram_rdata;
          state_d = fbic_pkg::S_LIM;
        end
      end

      // Block end against the address space.
      fbic_pkg::S_LIM: begin
        alu_a       = ALU_W'(bstart_q);
        alu_b       = ALU_W'(bsize_q);
        alu_c       = fbic_pkg::SPACE_LIMIT;
        range_bad_d = !alu_res.lt && !alu_res.eq;
        state_d     = fbic_pkg::S_NXT;
      end

      // Block end against the following entry.
      fbic_pkg::S_NXT: begin
        alu_a   = ALU_W'(bstart_q);
        alu_b   = ALU_W'(bsize_q);
        alu_c   = ALU_W'(next_q.start);
        mnext_d = (pos_q < n_q) && alu_res.eq;
        state_d = fbic_pkg::S_PRV;
      end

      // Preceding entry end against the block start.
      fbic_pkg::S_PRV: begin
        alu_a   = ALU_W'(prev_q.start);
        alu_b   = ALU_W'(prev_q.size);
        alu_c   = ALU_W'(bstart_q);
        mprev_d = (pos_q != '0) && alu_res.eq;
        state_d = fbic_pkg::S_DEC;
      end

      // Pick the outcome; a new entry first opens its slot from the top down.
      fbic_pkg::S_DEC: begin
        ram_raddr = n_m1[IW-1:0];
        sh_d      = n_m1[IW-1:0];
        if (refuse) begin
          status_d    = fbic_pkg::ST_REFUSED;
          idx_d       = '0;
          res_start_d = '0;
          acc_d       = '0;
          state_d     = fbic_pkg::S_DONE;
        end else if (mnext_q || mprev_q) begin
          status_d    = mnext_q ? (mprev_q ? fbic_pkg::ST_BOTH : fbic_pkg::ST_NEXT)
                                : fbic_pkg::ST_PREV;
          idx_d       = mprev_q ? pos_m1[IW-1:0] : pos_q[IW-1:0];
          res_start_d = mprev_q ? prev_q.start : bstart_q;
          state_d     = fbic_pkg::S_SUM1;
        end else begin
          status_d    = fbic_pkg::ST_NEW;
          idx_d       = pos_q[IW-1:0];
          res_start_d = bstart_q;
          acc_d       = ALU_W'(bsize_q);
          state_d     = (pos_q < n_q) ? fbic_pkg::S_UP : fbic_pkg::S_WR;
        end
      end

      // Merged size: neighbor size plus the block.
      fbic_pkg::S_SUM1: begin
        alu_a   = mprev_q ? ALU_W'(prev_q.size) : ALU_W'(next_q.size);
        alu_b   = ALU_W'(bsize_q);
        acc_d   = alu_res.sum;
        state_d = (status_q == fbic_pkg::ST_BOTH) ? fbic_pkg::S_SUM2 : fbic_pkg::S_WR;
      end

      // Both neighbors merge: add the following entry as well.
      fbic_pkg::S_SUM2: begin
        alu_a   = acc_q;
        alu_b   = ALU_W'(next_q.size);
        acc_d   = alu_res.sum;
        state_d = fbic_pkg::S_WR;
      end

      // Move one entry up per cycle while the next lower one is read.
      fbic_pkg::S_UP: begin
        ram_we    = 1'b1;
        ram_waddr = sh_q + IW'(1);
        ram_wdata = ram_rdata;
        ram_raddr = sh_q - IW'(1);
        if (CW'(sh_q) == pos_q) begin
          state_d = fbic_pkg::S_WR;
        end else begin
          sh_d = sh_q - IW'(1);
        end
      end

      // Write the resulting entry; a double merge then closes the slot above it.
      fbic_pkg::S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = '{start: res_start_q, size: sat_size};
        ram_raddr = pos_q[IW-1:0] + IW'(1);
        sh_d      = pos_q[IW-1:0] + IW'(1);
        if ((status_q == fbic_pkg::ST_BOTH) && (pos_p1 < n_q)) begin
          state_d = fbic_pkg::S_DN;
        end else begin
          state_d = fbic_pkg::S_DONE;
        end
      end

      // Move one entry down per cycle while the next higher one is read.
      fbic_pkg::S_DN: begin
        ram_we    = 1'b1;
        ram_waddr = sh_q - IW'(1);
        ram_wdata = ram_rdata;
        ram_raddr = sh_q + IW'(1);
        if (CW'(sh_q) == n_m1) begin
          state_d = fbic_pkg::S_DONE;
        end else begin
          sh_d = sh_q + IW'(1);
        end
      end

      // Hand the result over once the result register is free.
      fbic_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_index_d  = fbic_pkg::INDEX_W'(idx_q);
          out_start_d  = res_start_q;
          out_size_d   = sat_size;
          out_count_d  = fbic_pkg::COUNT_W'(n_next);
          n_d          = n_next;
          state_d      = fbic_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = fbic_pkg::S_IDLE;
      end
    endcase
  end

  // State register and control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbic_pkg::S_IDLE;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    bstart_q     <= bstart_d;
    bsize_q      <= bsize_d;
    pos_q        <= pos_d;
    sh_q         <= sh_d;
    prev_q       <= prev_d;
    next_q       <= next_d;
    range_bad_q  <= range_bad_d;
    mnext_q      <= mnext_d;
    mprev_q      <= mprev_d;
    acc_q        <= acc_d;
    res_start_q  <= res_start_d;
    idx_q        <= idx_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_start_q  <= out_start_d;
    out_size_q   <= out_size_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign entry_index_o  = out_index_q;
  assign merged_start_o = out_start_q;
  assign merged_size_o  = out_size_q;
  assign entry_count_o  = out_count_q;

  // The table never holds more entries than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(MAX_BLOCKS))
    else $error("entry count exceeds table depth");

  // The entry count only moves when a result is handed over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fbic_pkg::S_DONE) |=> $stable(n_q))
    else $error("entry count changed outside result hand-over");

  // A refused request reports an empty result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == fbic_pkg::ST_REFUSED)) |->
      ((out_size_q == '0) && (out_index_q == '0) && (out_start_q == '0)))
    else $error("refused result carries data");

  // An accepted block always yields a non-empty entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != fbic_pkg::ST_REFUSED)) |-> (out_size_q != '0))
    else $error("empty entry reported for accepted block");

  // The table RAM is written only while placing or moving entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == fbic_pkg::S_WR) || (state_q == fbic_pkg::S_UP) ||
                (state_q == fbic_pkg::S_DN)))
    else $error("table written outside an update step");

endmodule
